// ===== rtl/twgd_pkg.sv =====
// Shared types and constants for the trapezoid weighted grid dot block.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package twgd_pkg;

  localparam int unsigned GRID_MAX = 4096;
  localparam int unsigned IDX_W    = $clog2(GRID_MAX);
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned SUM_W    = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(GRID_MAX - 1);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL_FIRST = 3'd0,
    REG_COL_LAST  = 3'd1,
    REG_ROW_FIRST = 3'd2,
    REG_ROW_LAST  = 3'd3,
    REG_EDGE_COL  = 3'd4,
    REG_EDGE_ROW  = 3'd5,
    REG_STEP_X    = 3'd6,
    REG_STEP_Y    = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_AB,
    ST_ABS,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM_Q,
    ST_ACC,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic mul_ab;
    logic abs_val;
    logic mul_lo;
    logic mul_hi;
    logic sum_q;
    logic acc;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/trapezoid_weighted_grid_dot_top.sv =====
// Top level of the trapezoid weighted grid dot block.
// Depends on twgd_pkg, twgd_ctrl and twgd_dp.
//
//   Channel | Direction | Signals                        | Contents
//   --------+-----------+--------------------------------+--------------------------------
//   s_axis  | in        | tvalid, tready, tdata[63:0]    | first_value, second_value
//   m_axis  | out       | tvalid, tready, tdata, tuser   | dot_sum; tuser = saturated
//   cfg     | in        | cfg_we_i, cfg_idx_i, cfg_data_i| register writes, no read-back
//
// Each word passes, from acceptance to the next ready, through one signed
// 32x32 product, a magnitude stage, two passes of a shared 32x32 unsigned multiplier
// against the cell area, a weighting add with the halving shift, and the saturating
// accumulate. The word that closes the window then goes through the step that loads the result register.
// The result register holds its word while a new input word is accepted; the block
// only waits in the load step if the previous result has not yet been taken.
// Reset clears the state machine, the configuration, counters, sum and clip flag;
// any configuration write restarts the pass from the window's first cell.
`default_nettype none

module trapezoid_weighted_grid_dot_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Configuration write port.
  input  wire logic                                 cfg_we_i,
  input  wire logic [twgd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [twgd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Input words.
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // [31:0] first_value, [63:32] second_value
  input  wire logic [2*twgd_pkg::VAL_W-1:0]         s_axis_tdata,
  // Result words.
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [63:0] dot_sum
  output logic [twgd_pkg::SUM_W-1:0]                m_axis_tdata,
  // [0] saturated
  output logic                                      m_axis_tuser
);
  import twgd_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The controller sequences each word through the datapath stages.
  twgd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // The datapath holds the configuration, counters and arithmetic.
  twgd_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_sum_o  (m_axis_tdata),
    .out_sat_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/twgd_ctrl.sv =====
// Sequencing state machine of the trapezoid weighted grid dot block.
// Depends on twgd_pkg; drives the datapath through cmd_t and owns the output valid.
`default_nettype none

module twgd_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output twgd_pkg::cmd_t       cmd_o,
  input  wire twgd_pkg::status_t status_i
);
  import twgd_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_MUL_AB;
        end
      end
      ST_MUL_AB: begin
        cmd_o.mul_ab = 1'b1;
        state_d      = ST_ABS;
      end
      ST_ABS: begin
        cmd_o.abs_val = 1'b1;
        state_d       = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_SUM_Q;
      end
      ST_SUM_Q: begin
        cmd_o.sum_q = 1'b1;
        state_d     = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = status_i.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // The result register is free when empty or being drained this cycle.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/twgd_dp.sv =====
// Datapath of the trapezoid weighted grid dot block: configuration registers,
// window counters, multipliers, saturating accumulator and result register. Uses twgd_pkg.
`default_nettype none

module twgd_dp (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [twgd_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [twgd_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  wire logic [2*twgd_pkg::VAL_W-1:0]           in_data_i,
  input  wire twgd_pkg::cmd_t                         cmd_i,
  output twgd_pkg::status_t                           status_o,
  output logic [twgd_pkg::SUM_W-1:0]                  out_sum_o,
  output logic                                        out_sat_o
);
  import twgd_pkg::*;

  // Configuration.
  logic [IDX_W-1:0]  col_first_q, col_last_q, row_first_q, row_last_q;
  logic [IDX_W-1:0]  edge_col_q, edge_row_q;
  logic [STEP_W-1:0] step_x_q, step_y_q;
  logic [2*STEP_W-1:0] area_q;

  // Pass state.
  logic [IDX_W-1:0] col_q, row_q;
  logic [SUM_W-1:0] sum_q;
  logic             clip_q;
  logic             last_q;

  // Per-word pipeline registers.
  logic signed [VAL_W-1:0] a_q, b_q;
  logic [1:0]              halve_q;
  logic signed [SUM_W-1:0] prod_q;
  logic [SUM_W-2:0]        mag_q;
  logic                    neg_q;
  logic [VAL_W-1:0]        lo_part_q;
  logic [SUM_W-1:0]        hi_part_q;
  logic [SUM_W-1:0]        q_q;
  logic [SUM_W-1:0]        res_sum_q;
  logic                    res_sat_q;

  logic             col_end, row_end;
  logic [1:0]       halve_d;
  logic [VAL_W-1:0] mul_op;
  logic [SUM_W-1:0] mul_res;
  logic [SUM_W:0]   acc_ext, term_ext, acc_res;
  logic [SUM_W-1:0] sat_val;
  logic             ovf;

  assign col_end = (col_q == col_last_q) || (col_q == IDX_TOP);
  assign row_end = (row_q == row_last_q) || (row_q == IDX_TOP);
  assign halve_d = {1'b0, (col_q == '0) || (col_q == edge_col_q)}
                 + {1'b0, (row_q == '0) || (row_q == edge_row_q)};

  // Configuration registers; every write restarts the pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_first_q <= '0;
      col_last_q  <= '0;
      row_first_q <= '0;
      row_last_q  <= '0;
      edge_col_q  <= '0;
      edge_row_q  <= '0;
      step_x_q    <= '0;
      step_y_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_COL_FIRST: col_first_q <= cfg_data_i[IDX_W-1:0];
        REG_COL_LAST:  col_last_q  <= cfg_data_i[IDX_W-1:0];
        REG_ROW_FIRST: row_first_q <= cfg_data_i[IDX_W-1:0];
        REG_ROW_LAST:  row_last_q  <= cfg_data_i[IDX_W-1:0];
        REG_EDGE_COL:  edge_col_q  <= cfg_data_i[IDX_W-1:0];
        REG_EDGE_ROW:  edge_row_q  <= cfg_data_i[IDX_W-1:0];
        REG_STEP_X:    step_x_q    <= cfg_data_i[STEP_W-1:0];
        REG_STEP_Y:    step_y_q    <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Cell area, refreshed every cycle from the step registers.
  always_ff @(posedge clk_i) begin
    area_q <= step_x_q * step_y_q;
  end

  // Counters, running sum and clip flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      sum_q  <= '0;
      clip_q <= 1'b0;
      last_q <= 1'b0;
    end else if (cfg_we_i) begin
      // Writes beyond the list cannot occur: the index field covers exactly eight registers.
      col_q  <= (cfg_idx_i == REG_COL_FIRST) ? cfg_data_i[IDX_W-1:0] : col_first_q;
      row_q  <= (cfg_idx_i == REG_ROW_FIRST) ? cfg_data_i[IDX_W-1:0] : row_first_q;
      sum_q  <= '0;
      clip_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        last_q <= col_end && row_end;
        if (!col_end) begin
          col_q <= col_q + 1'b1;
        end else begin
          col_q <= col_first_q;
          row_q <= row_end ? row_first_q : row_q + 1'b1;
        end
      end
      if (cmd_i.acc) begin
        sum_q <= ovf ? sat_val : acc_res[SUM_W-1:0];
        if (ovf) begin
          clip_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        sum_q  <= '0;
        clip_q <= 1'b0;
      end
    end
  end

  // Shared unsigned multiplier for the low and high halves of the magnitude.
  assign mul_op  = cmd_i.mul_lo ? mag_q[VAL_W-1:0] : {1'b0, mag_q[SUM_W-2:VAL_W]};
  assign mul_res = mul_op * area_q;

  // Accumulate: the sign of the term is applied through the carry-in.
  assign acc_ext  = {sum_q[SUM_W-1], sum_q};
  assign term_ext = neg_q ? ~{1'b0, q_q} : {1'b0, q_q};
  assign acc_res  = acc_ext + term_ext + {{SUM_W{1'b0}}, neg_q};
  assign ovf      = acc_res[SUM_W] != acc_res[SUM_W-1];
  assign sat_val  = acc_res[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      a_q     <= in_data_i[VAL_W-1:0];
      b_q     <= in_data_i[2*VAL_W-1:VAL_W];
      halve_q <= halve_d;
    end
    if (cmd_i.mul_ab) begin
      prod_q <= a_q * b_q;
    end
    if (cmd_i.abs_val) begin
      neg_q <= prod_q[SUM_W-1];
      mag_q <= prod_q[SUM_W-1] ? (SUM_W-1)'(-prod_q) : prod_q[SUM_W-2:0];
    end
    if (cmd_i.mul_lo) begin
      lo_part_q <= mul_res[SUM_W-1:VAL_W];
    end
    if (cmd_i.mul_hi) begin
      hi_part_q <= mul_res;
    end
    if (cmd_i.sum_q) begin
      q_q <= (hi_part_q + {{VAL_W{1'b0}}, lo_part_q}) >> halve_q;
    end
    if (cmd_i.emit) begin
      res_sum_q <= sum_q;
      res_sat_q <= clip_q;
    end
  end

  assign status_o.last = last_q;
  assign out_sum_o     = res_sum_q;
  assign out_sat_o     = res_sat_q;

endmodule

`default_nettype wire

// ===== bench/trapezoid_weighted_grid_dot_top_tb.sv =====
// Self-checking bench for trapezoid_weighted_grid_dot_top: drives paired field
// words and register writes, predicts every weighted window sum and checks it.
// Depends on twgd_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module trapezoid_weighted_grid_dot_top_tb;
  import twgd_pkg::*;

  // Covers every pipeline step of a word plus the result load; it is waited out
  // before a register write so that no word is still in flight.
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 600;
  localparam int WORDS_TOTAL  = 650;
  localparam int CALM_FROM    = 540;
  localparam int NUM_ROWS     = 38;

  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // [31:0] first_value, [63:32] second_value
  logic [2*VAL_W-1:0]     s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [63:0] dot_sum
  logic [SUM_W-1:0]       m_axis_tdata;
  // [0] saturated
  logic                   m_axis_tuser;

  trapezoid_weighted_grid_dot_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 20 ns period: ten high, ten low.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // A result word as the block should deliver it.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             sat;
  } dot_word_t;

  // Rows of the directed table: either a register write or a pair of values.
  // Where the sum can be read off directly it is typed in and used in place of
  // the prediction.
  typedef enum bit {ROW_WRITE, ROW_WORD} row_kind_e;
  typedef struct {
    row_kind_e   kind;
    cfg_reg_e    reg_idx;
    logic [15:0] reg_val;
    logic [31:0] first;
    logic [31:0] second;
    bit          typed;
    logic [63:0] sum;
    bit          sat;
  } stim_row_t;

  stim_row_t directed_rows [NUM_ROWS];

  // Shadow copy of the configuration registers.
  logic [IDX_W-1:0]  col_first, col_last, row_first, row_last, edge_col, edge_row;
  logic [STEP_W-1:0] step_x, step_y;

  // Shadow copy of the pass in progress.
  logic [IDX_W-1:0]  col_at, row_at;
  longint            acc_sum;
  bit                acc_clip;

  dot_word_t pending_sums [$];

  int  mismatches     = 0;
  int  words_in       = 0;
  int  sums_seen      = 0;
  int  saturated_seen = 0;
  int  settings_used  = 0;
  bit  calm           = 1'b0;
  bit  hold_off_req   = 1'b0;

  function automatic void restart_pass();
    col_at   = col_first;
    row_at   = row_first;
    acc_sum  = 0;
    acc_clip = 1'b0;
  endfunction

  // Any write restarts the pass from the window's first cell.
  function automatic void apply_write(cfg_reg_e r, logic [15:0] v);
    case (r)
      REG_COL_FIRST: col_first = v[IDX_W-1:0];
      REG_COL_LAST:  col_last  = v[IDX_W-1:0];
      REG_ROW_FIRST: row_first = v[IDX_W-1:0];
      REG_ROW_LAST:  row_last  = v[IDX_W-1:0];
      REG_EDGE_COL:  edge_col  = v[IDX_W-1:0];
      REG_EDGE_ROW:  edge_row  = v[IDX_W-1:0];
      REG_STEP_X:    step_x    = v;
      REG_STEP_Y:    step_y    = v;
      default: ;
    endcase
    restart_pass();
  endfunction

  // Weighs one pair by the (possibly halved) cell area, adds it with saturation
  // and moves the counters on. Returns 1 with the finished sum when the pair
  // closes the window.
  function automatic bit accumulate_cell(logic [31:0] a_bits, logic [31:0] b_bits,
                                         output dot_word_t done);
    longint      a, b, p, t;
    logic [63:0] mag, area, q;
    int          halvings;
    a = $signed(a_bits);
    b = $signed(b_bits);
    p = a * b;
    halvings = 0;
    if (col_at == '0 || col_at == edge_col) halvings++;
    if (row_at == '0 || row_at == edge_row) halvings++;
    area = {48'd0, step_x} * {48'd0, step_y};
    mag  = (p < 0) ? 64'(-p) : 64'(p);
    // Split the magnitude so that neither partial product leaves 64 bits.
    q = (mag >> 32) * area + (((mag & 64'hFFFF_FFFF) * area) >> 32);
    q = q >> halvings;
    t = (p < 0) ? -$signed(q) : $signed(q);
    if (t > 0 && acc_sum > SUM_MAX - t) begin
      acc_sum  = SUM_MAX;
      acc_clip = 1'b1;
    end else if (t < 0 && acc_sum < SUM_MIN - t) begin
      acc_sum  = SUM_MIN;
      acc_clip = 1'b1;
    end else begin
      acc_sum = acc_sum + t;
    end
    done = '0;
    if (col_at != col_last && col_at != IDX_TOP) begin
      col_at = col_at + 1'b1;
      return 1'b0;
    end
    col_at = col_first;
    if (row_at != row_last && row_at != IDX_TOP) begin
      row_at = row_at + 1'b1;
      return 1'b0;
    end
    done.sum = acc_sum;
    done.sat = acc_clip;
    restart_pass();
    return 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 2))
      0:       return IDX_W'($urandom_range(0, 3));
      1:       return IDX_W'($urandom_range(4092, 4095));
      default: return IDX_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return STEP_W'($urandom);
    endcase
  endfunction

  // Extremes come up often enough to reach saturation on interior cells.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // Offers one word, waits for the handshake and records what it should cause.
  task automatic offer_pair(logic [31:0] a, logic [31:0] b,
                            bit typed, logic [63:0] tsum, bit tsat);
    dot_word_t got;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    words_in++;
    if (accumulate_cell(a, b, got)) begin
      if (typed) begin
        got.sum = tsum;
        got.sat = tsat;
      end
      pending_sums.push_back(got);
    end
  endtask

  // Brings the block to rest: every expected sum delivered and any word that
  // closes no window worked through.
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_register(cfg_reg_e r, logic [15:0] v);
    cfg_idx_i  <= r;
    cfg_data_i <= v;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    apply_write(r, v);
  endtask

  // Result side: random stalls, one long hold-off on request, none at the end.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Every result word taken is compared with the oldest expected sum.
  always @(posedge clk_i) begin : check_sum
    dot_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sums_seen++;
      if (m_axis_tuser) saturated_seen++;
      if (pending_sums.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, dot_sum %h saturated %b",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_sums.pop_front();
        if (m_axis_tdata !== want.sum) begin
          mismatches++;
          $display("%0t: dot_sum expected %h got %h", $time, want.sum, m_axis_tdata);
        end
        if (m_axis_tuser !== want.sat) begin
          mismatches++;
          $display("%0t: saturated expected %b got %b", $time, want.sat, m_axis_tuser);
        end
      end
    end
  end

  initial begin
    logic [IDX_W-1:0] cf, cl, rf, rl;
    int               n_cols, n_rows, n_windows, part;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_COL_FIRST;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;

    // All registers are zero after reset: a single-cell window at the origin
    // with zero steps, so each word closes the window with a zero sum.
    col_first = '0;
    col_last  = '0;
    row_first = '0;
    row_last  = '0;
    edge_col  = '0;
    edge_row  = '0;
    step_x    = '0;
    step_y    = '0;
    restart_pass();

    directed_rows = '{
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 64'h0, 1'b0},
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h8000_0000, 32'h8000_0000, 1'b1, 64'h0, 1'b0},
      // Full steps, three interior cells on one row: no halving anywhere.
      '{ROW_WRITE, REG_STEP_X,    16'hFFFF, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WRITE, REG_STEP_Y,    16'hFFFF, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WRITE, REG_COL_FIRST, 16'h1,    32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WRITE, REG_COL_LAST,  16'h3,    32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WRITE, REG_ROW_FIRST, 16'h1,    32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WRITE, REG_ROW_LAST,  16'h1,    32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WRITE, REG_EDGE_COL,  16'hFFF,  32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WRITE, REG_EDGE_ROW,  16'hFFF,  32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      // Three largest positive products overrun the top of the sum.
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h8000_0000, 32'h8000_0000, 1'b0, 64'h0, 1'b0},
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h8000_0000, 32'h8000_0000, 1'b0, 64'h0, 1'b0},
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h8000_0000, 32'h8000_0000,
        1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1},
      // And three largest negative ones overrun the bottom.
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 64'h0, 1'b0},
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 64'h0, 1'b0},
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h8000_0000, 32'h7FFF_FFFF,
        1'b1, 64'h8000_0000_0000_0000, 1'b1},
      // A write in the middle of a window throws the partial sum away.
      '{ROW_WRITE, REG_COL_LAST,  16'h4,    32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 64'h0, 1'b0},
      '{ROW_WRITE, REG_EDGE_COL,  16'h2,    32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h0001_0000, 32'h0001_0000, 1'b0, 64'h0, 1'b0},
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 64'h0, 1'b0},
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 64'h0, 1'b0},
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h0001_0000, 32'hFFFF_0000, 1'b0, 64'h0, 1'b0},
      // First beyond last: columns run to the grid's top index, which ends
      // the line, and the top row ends the window.
      '{ROW_WRITE, REG_COL_FIRST, 16'hFFE,  32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WRITE, REG_COL_LAST,  16'h1,    32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WRITE, REG_ROW_FIRST, 16'hFFF,  32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WRITE, REG_ROW_LAST,  16'h0,    32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 64'h0, 1'b0},
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 64'h0, 1'b0},
      // Corner cells: index zero and the edge halve the area twice.
      '{ROW_WRITE, REG_COL_FIRST, 16'h0,    32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WRITE, REG_EDGE_COL,  16'h1,    32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WRITE, REG_ROW_FIRST, 16'h0,    32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WRITE, REG_STEP_X,    16'h8000, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h0001_0000, 32'hFFFF_0000, 1'b0, 64'h0, 1'b0},
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h0001_0000, 32'h0001_0000, 1'b0, 64'h0, 1'b0},
      // A zero step weighs everything to nothing.
      '{ROW_WRITE, REG_STEP_Y,    16'h0,    32'h0, 32'h0, 1'b0, 64'h0, 1'b0},
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 64'h0, 1'b0},
      '{ROW_WORD,  REG_COL_FIRST, 16'h0, 32'h8000_0000, 32'h8000_0000, 1'b1, 64'h0, 1'b0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        settle_block();
        write_register(directed_rows[i].reg_idx, directed_rows[i].reg_val);
        cfg_we_i <= 1'b0;
      end else begin
        offer_pair(directed_rows[i].first, directed_rows[i].second, directed_rows[i].typed,
                   directed_rows[i].sum, directed_rows[i].sat);
      end
    end

    // Random part: each setting is a small window somewhere on the grid,
    // mostly whole windows, now and then one cut short by the next setting.
    while (words_in < WORDS_TOTAL) begin
      settings_used++;
      if (words_in >= CALM_FROM) calm = 1'b1;

      cf = pick_index();
      cl = cf + IDX_W'($urandom_range(0, 3));
      if (cf >= 12'hFFC && $urandom_range(0, 4) == 0) cl = IDX_W'($urandom_range(0, cf - 1));
      rf = pick_index();
      rl = rf + IDX_W'($urandom_range(0, 2));
      if (rf >= 12'hFFC && $urandom_range(0, 4) == 0) rl = IDX_W'($urandom_range(0, rf - 1));
      n_cols = (cf <= cl) ? int'(cl) - int'(cf) + 1 : GRID_MAX - int'(cf);
      n_rows = (rf <= rl) ? int'(rl) - int'(rf) + 1 : GRID_MAX - int'(rf);

      settle_block();
      write_register(REG_COL_FIRST, 16'(cf));
      write_register(REG_COL_LAST,  16'(cl));
      write_register(REG_ROW_FIRST, 16'(rf));
      write_register(REG_ROW_LAST,  16'(rl));
      // The halving edge lands on the window's first or last cell, on the
      // grid top, or anywhere.
      case ($urandom_range(0, 3))
        0:       write_register(REG_EDGE_COL, 16'(cf));
        1:       write_register(REG_EDGE_COL, 16'(cl));
        2:       write_register(REG_EDGE_COL, 16'(IDX_TOP));
        default: write_register(REG_EDGE_COL, 16'(pick_index()));
      endcase
      case ($urandom_range(0, 3))
        0:       write_register(REG_EDGE_ROW, 16'(rf));
        1:       write_register(REG_EDGE_ROW, 16'(rl));
        2:       write_register(REG_EDGE_ROW, 16'(IDX_TOP));
        default: write_register(REG_EDGE_ROW, 16'(pick_index()));
      endcase
      write_register(REG_STEP_X, pick_step());
      write_register(REG_STEP_Y, pick_step());
      cfg_we_i <= 1'b0;

      // In the second setting the result side holds off for a long stretch
      // while words keep coming, so the block fills and stalls its input.
      if (settings_used == 2) hold_off_req = 1'b1;

      // At least three windows there, so that a word is still on offer once
      // two results are waiting.
      n_windows = (settings_used == 2) ? $urandom_range(3, 8) : $urandom_range(2, 8);
      repeat (n_windows * n_cols * n_rows) offer_pair(pick_value(), pick_value(), 0, '0, 0);
      if (n_cols * n_rows > 1 && $urandom_range(0, 4) == 0) begin
        part = $urandom_range(1, n_cols * n_rows - 1);
        repeat (part) offer_pair(pick_value(), pick_value(), 0, '0, 0);
      end
    end

    settle_block();
    $display("Covered %0d input words over %0d random window settings after the table.",
             words_in, settings_used);
    $display("Checked %0d result words, %0d of them saturated.", sums_seen, saturated_seen);
    if (mismatches == 0) begin
      $display("trapezoid_weighted_grid_dot_top_tb OK");
    end else begin
      $display("trapezoid_weighted_grid_dot_top_tb NOT OK");
    end
    $finish;
  end

  // A correct run takes well under a tenth of this.
  initial begin
    #10_000_000;
    $display("Timed out with %0d result words still expected.", pending_sums.size());
    $display("trapezoid_weighted_grid_dot_top_tb NOT OK");
    $finish;
  end

endmodule
